FILE: sv/cspc_pkg.sv
`default_nettype none
package cspc_pkg;

  // Timestamp field width on the stream and the edge counter width.
  localparam int STAMP_W = 16;
  localparam int EDGE_W = 16;

  // Shared divider: the speed numerator is the widest dividend, the
  // scaled period the widest divisor.
  localparam int DIVIDEND_W = 33;
  localparam int DIVISOR_W = 27;

  localparam int SPEED_W = 23;
  localparam int ERR_W = 24;
  localparam int DIFF_W = 25;
  localparam int INTEG_W = 21;
  localparam int PROD_W = 41;
  localparam int SUM_W = 27;
  localparam int DUTY_W = 8;
  localparam int CFG_W = 21;

  localparam logic [16:0] SPEED_NUM = 17'd93750;
  localparam logic [10:0] SPEED_DEN = 11'd1398;
  localparam logic [DUTY_W-1:0] DUTY_MAX = 8'hFF;
  localparam logic [EDGE_W-1:0] COUNT_MAX = 16'hFFFF;

  localparam logic [15:0] TARGET_RESET = 16'h60;
  localparam logic signed [INTEG_W-1:0] INT_LOW_RESET = 21'sd0;
  localparam logic signed [INTEG_W-1:0] INT_HIGH_RESET = 21'sd5;

  localparam logic [1:0] CFG_TARGET = 2'd0;
  localparam logic [1:0] CFG_INT_LOW = 2'd1;
  localparam logic [1:0] CFG_INT_HIGH = 2'd2;

  localparam logic OP_CAPTURE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam int QUEUE_DEPTH = 2;

  // Snapshot of the capture state that one control tick works on.
  typedef struct packed {
    logic [EDGE_W-1:0] edges;
    logic [STAMP_W-1:0] period;
  } tick_req_t;

endpackage
`default_nettype wire

FILE: sv/cspc_front.sv
`default_nettype none
module cspc_front #(
  parameter int STAMP_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  input  wire logic                       in_op,
  input  wire logic [cspc_pkg::STAMP_W-1:0] in_stamp,
  output logic                            in_ready,
  input  wire logic                       q_full,
  output logic                            q_push,
  output cspc_pkg::tick_req_t             q_entry
);
  import cspc_pkg::*;

  localparam int SW = (STAMP_BITS < STAMP_W) ? STAMP_BITS : STAMP_W;
  localparam logic [STAMP_W-1:0] STAMP_MASK = STAMP_W'((33'd1 << SW) - 33'd1);

  logic [STAMP_W-1:0] previous_stamp;
  logic [STAMP_W-1:0] last_period;
  logic [EDGE_W-1:0]  edge_counter;
  logic [EDGE_W-1:0]  latched_edges;

  logic               accept;
  logic [STAMP_W-1:0] stamp;

  assign in_ready = !q_full;
  assign accept = in_valid && !q_full;
  assign stamp = in_stamp & STAMP_MASK;
  assign q_push = accept && (in_op == OP_TICK);
  assign q_entry.edges = latched_edges;
  assign q_entry.period = last_period;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_stamp <= '0;
      last_period <= '0;
      edge_counter <= '0;
      latched_edges <= '0;
    end else if (accept && (in_op == OP_CAPTURE)) begin
      last_period <= (stamp - previous_stamp) & STAMP_MASK;
      previous_stamp <= stamp;
      // A timer wrap closes the counting window; this edge opens the next one.
      if (stamp < previous_stamp) begin
        latched_edges <= edge_counter;
        edge_counter <= EDGE_W'(1);
      end else if (edge_counter != COUNT_MAX) begin
        edge_counter <= edge_counter + EDGE_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/cspc_queue.sv
`default_nettype none
module cspc_queue (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire cspc_pkg::tick_req_t entry_in,
  input  wire logic    pop,
  output cspc_pkg::tick_req_t entry_out,
  output logic         full,
  output logic         empty
);
  import cspc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  tick_req_t          slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full = (count == CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign entry_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= entry_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/cspc_divider.sv
`default_nettype none
module cspc_divider (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [cspc_pkg::DIVIDEND_W-1:0] dividend,
  input  wire logic [cspc_pkg::DIVISOR_W-1:0]  divisor,
  output logic                               done,
  output logic [cspc_pkg::DIVIDEND_W-1:0]      quotient
);
  import cspc_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy;
  logic [CNT_W-1:0]      count;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  divisor_r;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W:0]    rem_shift;
  logic [DIVISOR_W+1:0]  trial;

  // Restoring division, one quotient bit per cycle; the dividend shifts out
  // of quo as the quotient bits shift in.
  assign rem_shift = {rem, quo[DIVIDEND_W-1]};
  assign trial = {1'b0, rem_shift} - {2'b00, divisor_r};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      divisor_r <= divisor;
      rem <= '0;
    end else if (busy) begin
      if (!trial[DIVISOR_W+1]) begin
        rem <= trial[DIVISOR_W-1:0];
        quo <= {quo[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem <= rem_shift[DIVISOR_W-1:0];
        quo <= {quo[DIVIDEND_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      count <= CNT_W'(DIVIDEND_W);
      done <= 1'b0;
    end else if (busy) begin
      count <= count - CNT_W'(1);
      if (count == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule
`default_nettype wire

FILE: sv/cspc_back.sv
`default_nettype none
module cspc_back (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire cspc_pkg::tick_req_t                req,
  input  wire logic                               req_valid,
  output logic                                    req_pop,
  input  wire logic [15:0]                        target_speed,
  input  wire logic signed [cspc_pkg::INTEG_W-1:0] integral_low,
  input  wire logic signed [cspc_pkg::INTEG_W-1:0] integral_high,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [cspc_pkg::DUTY_W-1:0]             duty,
  output logic [cspc_pkg::SPEED_W-1:0]            measured_speed
);
  import cspc_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_MUL      = 4'd1;
  localparam logic [3:0] S_SPD_GO   = 4'd2;
  localparam logic [3:0] S_SPD_WAIT = 4'd3;
  localparam logic [3:0] S_ERR      = 4'd4;
  localparam logic [3:0] S_PROD     = 4'd5;
  localparam logic [3:0] S_CLAMP    = 4'd6;
  localparam logic [3:0] S_DER_GO   = 4'd7;
  localparam logic [3:0] S_DER_WAIT = 4'd8;
  localparam logic [3:0] S_SUM      = 4'd9;

  logic [3:0]                state;
  logic [EDGE_W-1:0]         edges_r;
  logic [STAMP_W-1:0]        period_r;
  logic [DIVIDEND_W-1:0]     num_r;
  logic [DIVISOR_W-1:0]      den_r;
  logic [SPEED_W-1:0]        speed_r;
  logic signed [ERR_W-1:0]   err_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [DIFF_W-1:0]  diff_r;
  logic signed [INTEG_W-1:0] integ_r;
  logic signed [DIFF_W-1:0]  deriv_r;
  logic signed [INTEG_W-1:0] integral_sum;
  logic signed [ERR_W-1:0]   previous_error;

  logic                      div_start;
  logic [DIVIDEND_W-1:0]     div_dividend;
  logic [DIVISOR_W-1:0]      div_divisor;
  logic                      div_done;
  logic [DIVIDEND_W-1:0]     div_quotient;

  logic signed [ERR_W-1:0]   err_next;
  logic signed [PROD_W-1:0]  prod_next;
  logic signed [DIFF_W-1:0]  diff_next;
  logic signed [PROD_W-1:0]  integ_wide;
  logic signed [PROD_W-1:0]  low_wide;
  logic signed [PROD_W-1:0]  high_wide;
  logic signed [PROD_W-1:0]  integ_lo;
  logic signed [PROD_W-1:0]  integ_hi;
  logic [DIFF_W-1:0]         abs_diff;
  logic [DIFF_W-1:0]         deriv_mag;
  logic signed [SUM_W-1:0]   u_sum;
  logic [DUTY_W-1:0]         duty_next;
  logic                      out_free;

  cspc_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign req_pop = (state == S_IDLE) && req_valid;
  assign out_free = !out_valid || out_ready;

  assign abs_diff = diff_r[DIFF_W-1] ? $unsigned(-diff_r) : $unsigned(diff_r);
  assign deriv_mag = div_quotient[DIFF_W-1:0];

  assign div_start = (state == S_SPD_GO) || (state == S_DER_GO);
  assign div_dividend = (state == S_SPD_GO) ? num_r : DIVIDEND_W'(abs_diff);
  assign div_divisor = (state == S_SPD_GO) ? den_r : DIVISOR_W'(period_r);

  assign err_next = $signed({8'd0, target_speed}) - $signed({1'b0, speed_r});
  assign prod_next = err_r * $signed({1'b0, period_r});
  assign diff_next = DIFF_W'(err_r) - DIFF_W'(previous_error);

  // The low bound is applied first, so the high bound wins when they cross.
  assign integ_wide = PROD_W'(integral_sum) + prod_r;
  assign low_wide = PROD_W'(integral_low);
  assign high_wide = PROD_W'(integral_high);
  assign integ_lo = (integ_wide < low_wide) ? low_wide : integ_wide;
  assign integ_hi = (integ_lo > high_wide) ? high_wide : integ_lo;

  assign u_sum = SUM_W'(err_r) + SUM_W'(integ_r) + SUM_W'(deriv_r);

  always_comb begin
    if (u_sum < 0) begin
      duty_next = '0;
    end else if (u_sum > SUM_W'(DUTY_MAX)) begin
      duty_next = DUTY_MAX;
    end else begin
      duty_next = u_sum[DUTY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          edges_r <= req.edges;
          period_r <= req.period;
        end
      end
      S_MUL: begin
        num_r <= edges_r * SPEED_NUM;
        den_r <= SPEED_DEN * period_r;
        if (period_r == '0) begin
          speed_r <= '0;
        end
      end
      S_SPD_WAIT: begin
        if (div_done) begin
          speed_r <= div_quotient[SPEED_W-1:0];
        end
      end
      S_ERR: begin
        err_r <= err_next;
      end
      S_PROD: begin
        prod_r <= prod_next;
        diff_r <= diff_next;
      end
      S_CLAMP: begin
        integ_r <= integ_hi[INTEG_W-1:0];
        if (period_r == '0) begin
          deriv_r <= '0;
        end
      end
      S_DER_WAIT: begin
        // The division runs on magnitudes, which truncates toward zero.
        if (div_done) begin
          deriv_r <= diff_r[DIFF_W-1] ? $signed(DIFF_W'(0) - deriv_mag) : $signed(deriv_mag);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if ((state == S_SUM) && out_free) begin
      duty <= duty_next;
      measured_speed <= speed_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      integral_sum <= '0;
      previous_error <= '0;
    end else begin
      if (out_valid && out_ready && (state != S_SUM)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= (period_r == '0) ? S_ERR : S_SPD_GO;
        end
        S_SPD_GO: begin
          state <= S_SPD_WAIT;
        end
        S_SPD_WAIT: begin
          if (div_done) begin
            state <= S_ERR;
          end
        end
        S_ERR: begin
          state <= S_PROD;
        end
        S_PROD: begin
          state <= S_CLAMP;
        end
        S_CLAMP: begin
          state <= (period_r == '0) ? S_SUM : S_DER_GO;
        end
        S_DER_GO: begin
          state <= S_DER_WAIT;
        end
        S_DER_WAIT: begin
          if (div_done) begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          if (out_free) begin
            out_valid <= 1'b1;
            integral_sum <= integ_r;
            previous_error <= err_r;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: sv/capture_speed_pid_controller.sv
// An accepted capture request updates the period and edge count at once.
// A control tick is popped and scaled, then m_axis_tvalid rises after two divider passes
// (speed, then derivative) and four PID steps.
// With a zero period both divisions are skipped.
// Ticks wait in a two-entry queue; a queued tick starts the cycle after a result is posted.
// Synchronous active-high reset clears control state; target and bounds reload defaults.
`default_nettype none
module capture_speed_pid_controller #(
  parameter int STAMP_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] timestamp
  input  wire logic        s_axis_tuser,   // [0] op (0 capture, 1 control tick)
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [7:0] duty, [30:8] measured_speed, [31] zero
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [20:0] cfg_data
);
  import cspc_pkg::*;

  logic [15:0]               target_speed;
  logic signed [INTEG_W-1:0] integral_low;
  logic signed [INTEG_W-1:0] integral_high;

  logic                      q_full;
  logic                      q_empty;
  logic                      q_push;
  logic                      q_pop;
  tick_req_t                 q_in;
  tick_req_t                 q_out;
  logic [DUTY_W-1:0]         duty;
  logic [SPEED_W-1:0]        measured_speed;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_speed <= TARGET_RESET;
      integral_low <= INT_LOW_RESET;
      integral_high <= INT_HIGH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TARGET:   target_speed <= cfg_data[15:0];
        CFG_INT_LOW:  integral_low <= $signed(cfg_data);
        CFG_INT_HIGH: integral_high <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  cspc_front #(
    .STAMP_BITS (STAMP_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_op    (s_axis_tuser),
    .in_stamp (s_axis_tdata),
    .in_ready (s_axis_tready),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_in)
  );

  cspc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .entry_in  (q_in),
    .pop       (q_pop),
    .entry_out (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  cspc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .req            (q_out),
    .req_valid      (!q_empty),
    .req_pop        (q_pop),
    .target_speed   (target_speed),
    .integral_low   (integral_low),
    .integral_high  (integral_high),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .duty           (duty),
    .measured_speed (measured_speed)
  );

  assign m_axis_tdata = {1'b0, measured_speed, duty};

endmodule
`default_nettype wire
